// ===== rtl/lkv_pkg.sv =====
// Shared constants, types and records of the LRU key-value cache.
package lkv_pkg;

  // Storage geometry.
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int RANK_W  = IDX_W;
  localparam int USED_W  = $clog2(ENTRIES + 1);

  // Field widths.
  localparam int CAP_W  = 5;
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;

  // Capacity after reset and the value a get returns on a miss.
  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic [DATA_W-1:0] READ_MISS = '1;

  // Request kinds.
  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } req_e;

  // Entry arrays as seen by the lookup logic.
  typedef logic [ENTRIES-1:0][KEY_W-1:0]  key_vec_t;
  typedef logic [ENTRIES-1:0][DATA_W-1:0] data_vec_t;
  typedef logic [ENTRIES-1:0][RANK_W-1:0] rank_vec_t;

  // Table update for one item.
  typedef struct packed {
    logic              en;         // touch or fill a slot
    logic              set_valid;  // slot newly becomes valid
    logic              write_key;
    logic              write_data;
    logic [IDX_W-1:0]  slot;
    logic [RANK_W-1:0] age_below;  // other valid slots with a smaller rank age by one
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } upd_t;

  // Result of one item.
  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
  } res_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
//
// Usage: requests arrive on the slave stream. tuser carries the request kind
// (0 get, 1 put); tdata carries the key in the low 32 bits and the value in
// the high 32 bits. Every request gives exactly one item on the master
// stream: tdata is the read value (stored value on a get hit, all ones on a
// get miss, zero on a put) and tuser carries found (bit 0) and evicted (bit 1).
// An item passes an input register, is decided by one stage of parallel key
// compare and rank update over all 16 slots, and lands in a result register.
// The result is offered from the result register, and one item per cycle is
// sustained while the master side does not stall. The next item sees the table
// as left by the previous one.
// When the master side stalls, the result register holds its item, the input
// register holds one more, and s_axis_tready drops until the result is taken.
// Reset empties the cache at once (valid bits, ranks and fill count cleared)
// and sets the capacity to 16. The user writes the capacity through cfg_we_i
// and cfg_data_i only while no request is in flight; not enforced by the block.
module lru_key_value_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: capacity in use
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
  input  logic [0:0]  s_axis_tuser,   // req_type [0]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // read_value [31:0]
  output logic [1:0]  m_axis_tuser    // found [0], evicted [1]
);
  import lkv_pkg::*;

  logic [CAP_W-1:0]   cap_q;
  logic               in_valid_q;
  req_e               in_type_q;
  logic [KEY_W-1:0]   in_key_q;
  logic [DATA_W-1:0]  in_value_q;
  logic               out_valid_q;
  res_t               out_q;
  logic               proc_fire;
  logic               in_take;
  upd_t               upd;
  upd_t               upd_gated;
  res_t               res;
  logic [ENTRIES-1:0] valid;
  key_vec_t           keys;
  data_vec_t          datas;
  rank_vec_t          ranks;
  logic [USED_W-1:0]  used;

  // Handshake: decide when the result register is free or being drained.
  assign proc_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_type_q  <= req_e'(s_axis_tuser[0]);
      in_key_q   <= s_axis_tdata[KEY_W-1:0];
      in_value_q <= s_axis_tdata[KEY_W+DATA_W-1:KEY_W];
    end
  end

  // Decision for the item in the input register.
  lkv_decide u_decide (
    .req_type_i (in_type_q),
    .key_i      (in_key_q),
    .value_i    (in_value_q),
    .valid_i    (valid),
    .keys_i     (keys),
    .datas_i    (datas),
    .ranks_i    (ranks),
    .used_i     (used),
    .cap_i      (cap_q),
    .upd_o      (upd),
    .res_o      (res)
  );

  // The table changes only when the item actually moves on.
  always_comb begin
    upd_gated    = upd;
    upd_gated.en = upd.en && proc_fire;
  end

  lkv_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd_gated),
    .valid_o (valid),
    .keys_o  (keys),
    .datas_o (datas),
    .ranks_o (ranks),
    .used_o  (used)
  );

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_q.read_value;
  assign m_axis_tuser[0] = out_q.found;
  assign m_axis_tuser[1] = out_q.evicted;

  // A processed item always shows up in the result register next cycle.
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire |=> m_axis_tvalid)
    else $error("processed item did not reach the result register");

  // An eviction only happens on a put that missed.
  a_evict_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_q.found && out_q.evicted))
    else $error("result both found and evicted");

endmodule

// ===== rtl/lkv_decide.sv =====
// Parallel key match, victim and free slot search, and per-item decision.
module lkv_decide (
  input  lkv_pkg::req_e                     req_type_i,
  input  logic [lkv_pkg::KEY_W-1:0]         key_i,
  input  logic [lkv_pkg::DATA_W-1:0]        value_i,
  input  logic [lkv_pkg::ENTRIES-1:0]       valid_i,
  input  lkv_pkg::key_vec_t                 keys_i,
  input  lkv_pkg::data_vec_t                datas_i,
  input  lkv_pkg::rank_vec_t                ranks_i,
  input  logic [lkv_pkg::USED_W-1:0]        used_i,
  input  logic [lkv_pkg::CAP_W-1:0]         cap_i,
  output lkv_pkg::upd_t                     upd_o,
  output lkv_pkg::res_t                     res_o
);
  import lkv_pkg::*;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] is_old;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               old_ok;
  logic [IDX_W-1:0]   old_idx;
  logic               free_ok;
  logic [IDX_W-1:0]   free_idx;
  logic [USED_W-1:0]  used_m1;
  logic [USED_W-1:0]  cap_eff;
  logic               need_evict;

  // The least recent valid slot holds the rank one below the fill count.
  assign used_m1 = used_i - USED_W'(1);

  // Compare all slots at once.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_i[i] && (keys_i[i] == key_i);
      is_old[i] = valid_i[i] && (ranks_i[i] == used_m1[RANK_W-1:0]);
    end
  end

  // Priority encoders: the lowest slot wins.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    old_ok   = 1'b0;
    old_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (is_old[i]) begin
        old_ok  = 1'b1;
        old_idx = IDX_W'(i);
      end
      if (!valid_i[i]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // A capacity of zero acts as one, and values above the slot count saturate.
  always_comb begin
    if (cap_i == '0) begin
      cap_eff = USED_W'(1);
    end else if (USED_W'(cap_i) > USED_W'(ENTRIES)) begin
      cap_eff = USED_W'(ENTRIES);
    end else begin
      cap_eff = USED_W'(cap_i);
    end
  end

  assign need_evict = (used_i >= cap_eff);

  // Choose between hit, miss, evicting insert and plain insert.
  always_comb begin
    upd_o            = '0;
    upd_o.key        = key_i;
    upd_o.data       = value_i;
    res_o            = '0;
    if (hit) begin
      res_o.found     = 1'b1;
      upd_o.en        = 1'b1;
      upd_o.slot      = hit_idx;
      upd_o.age_below = ranks_i[hit_idx];
      if (req_type_i == REQ_GET) begin
        res_o.read_value = datas_i[hit_idx];
      end else begin
        upd_o.write_data = 1'b1;
      end
    end else if (req_type_i == REQ_GET) begin
      res_o.read_value = READ_MISS;
    end else if (need_evict) begin
      if (old_ok) begin
        res_o.evicted    = 1'b1;
        upd_o.en         = 1'b1;
        upd_o.slot       = old_idx;
        upd_o.age_below  = ranks_i[old_idx];
        upd_o.write_key  = 1'b1;
        upd_o.write_data = 1'b1;
      end
    end else if (free_ok) begin
      upd_o.en         = 1'b1;
      upd_o.set_valid  = 1'b1;
      upd_o.slot       = free_idx;
      upd_o.age_below  = RANK_W'(ENTRIES - 1);
      upd_o.write_key  = 1'b1;
      upd_o.write_data = 1'b1;
    end
  end

endmodule

// ===== rtl/lkv_table.sv =====
// Entry storage: valid bits, keys, values, recency ranks and fill count.
module lkv_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lkv_pkg::upd_t               upd_i,
  output logic [lkv_pkg::ENTRIES-1:0] valid_o,
  output lkv_pkg::key_vec_t           keys_o,
  output lkv_pkg::data_vec_t          datas_o,
  output lkv_pkg::rank_vec_t          ranks_o,
  output logic [lkv_pkg::USED_W-1:0]  used_o
);
  import lkv_pkg::*;

  logic [ENTRIES-1:0] valid_q, valid_d;
  rank_vec_t          rank_q, rank_d;
  key_vec_t           key_q;
  data_vec_t          data_q;
  logic [USED_W-1:0]  used_q, used_d;

  // Recency and validity update: the touched slot becomes the most recent.
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    used_d  = used_q;
    if (upd_i.en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (upd_i.slot == IDX_W'(i)) begin
          rank_d[i] = '0;
          if (upd_i.set_valid) begin
            valid_d[i] = 1'b1;
          end
        end else if (valid_q[i] && (rank_q[i] < upd_i.age_below)) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
      if (upd_i.set_valid) begin
        used_d = used_q + USED_W'(1);
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '0;
      used_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      used_q  <= used_d;
    end
  end

  // Key and value payload, written only at the chosen slot.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (upd_i.en && (upd_i.slot == IDX_W'(i))) begin
        if (upd_i.write_key) begin
          key_q[i] <= upd_i.key;
        end
        if (upd_i.write_data) begin
          data_q[i] <= upd_i.data;
        end
      end
    end
  end

  assign valid_o = valid_q;
  assign keys_o  = key_q;
  assign datas_o = data_q;
  assign ranks_o = rank_q;
  assign used_o  = used_q;

  // The fill count always equals the number of valid slots.
  a_used_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q == USED_W'($countones(valid_q)))
    else $error("fill count differs from number of valid slots");

  // The fill count never exceeds the slot count.
  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(ENTRIES))
    else $error("fill count above slot count");

  // A fill targets a free slot, which is valid and most recent afterwards.
  a_fill_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_i.en && upd_i.set_valid) |=>
      (valid_q[$past(upd_i.slot)] && (rank_q[$past(upd_i.slot)] == '0)))
    else $error("filled slot not valid and most recent");

endmodule
